### src/rlbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbe_pkg
// Shared types, constants and helpers of the run-length byte encoder.
// ----------------------------------------------------------------------------
package rlbe_pkg;

   localparam int DATA_W      = 8;
   localparam int RUN_W       = 7;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [RUN_W-1:0]  MAX_RUN_RESET = 7'd127;
   localparam logic [RUN_W-1:0]  MIN_RUN       = 7'd2;
   localparam logic [DATA_W-1:0] LITERAL_ONE   = 8'h01;

   // one two-byte group waiting to go out
   typedef struct packed {
      logic [DATA_W-1:0] control;
      logic [DATA_W-1:0] value;
      logic              item_last;
      logic              stream_end;
   } group_type;

   // up to two groups written by the front end in one cycle
   typedef struct packed {
      logic      en_a;
      logic      en_b;
      group_type grp_a;
      group_type grp_b;
   } push_type;

   function automatic logic [DATA_W-1:0] control_of(input logic [RUN_W-1:0] run);
      logic [DATA_W-1:0] ctrl;
      if (run >= MIN_RUN) begin
         ctrl = {1'b1, run};
      end else begin
         ctrl = LITERAL_ONE;
      end
      return ctrl;
   endfunction

endpackage
`default_nettype wire

### src/rlbe_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbe_req_if
// Raw byte stream channel into the encoder.
// ----------------------------------------------------------------------------
interface rlbe_req_if;
   logic                        valid;
   logic                        ready;
   logic [rlbe_pkg::DATA_W-1:0] data_byte;
   logic                        stream_last;

   modport source (output valid, output data_byte, output stream_last, input ready);
   modport sink   (input valid, input data_byte, input stream_last, output ready);
endinterface
`default_nettype wire

### src/rlbe_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbe_rsp_if
// Compressed byte stream channel out of the encoder.
// ----------------------------------------------------------------------------
interface rlbe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rlbe_pkg::DATA_W-1:0] code_byte;
   logic                        item_last;
   logic                        stream_end;

   modport source (output valid, output code_byte, output item_last, output stream_end,
                   input ready);
   modport sink   (input valid, input code_byte, input item_last, input stream_end,
                   output ready);
endinterface
`default_nettype wire

### src/rlbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbe_front
// Holds the pending run, classifies each input byte and pushes the groups
// it flushes (none, one or two) into the group queue.
// ----------------------------------------------------------------------------
module rlbe_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rlbe_req_if.sink                              req_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [rlbe_pkg::RUN_W-1:0]       csr_wr_data,
   input  wire logic                             space_ok,
   output rlbe_pkg::push_type                    push
);

   logic                         pend_valid_ff, pend_valid_in;
   logic [rlbe_pkg::DATA_W-1:0]  pend_value_ff, pend_value_in;
   logic [rlbe_pkg::RUN_W-1:0]   run_len_ff,    run_len_in;
   logic [rlbe_pkg::RUN_W-1:0]   max_run_ff,    max_run_in;

   logic                         accept;
   logic [rlbe_pkg::RUN_W-1:0]   limit;
   logic                         extend;
   logic [rlbe_pkg::RUN_W-1:0]   new_run;
   logic                         flush_b;

   assign req_chan.ready = space_ok;
   assign accept         = req_chan.valid && space_ok;

   always_comb begin
      limit   = (max_run_ff < rlbe_pkg::MIN_RUN) ? rlbe_pkg::MIN_RUN : max_run_ff;
      extend  = pend_valid_ff && (req_chan.data_byte == pend_value_ff) && (run_len_ff < limit);
      new_run = extend ? (run_len_ff + 7'd1) : 7'd1;
      flush_b = (new_run >= limit) || req_chan.stream_last;

      // group a: the old pending entry, pushed out by a byte that does not extend it
      push.en_a                 = accept && !extend && pend_valid_ff;
      push.grp_a.control        = rlbe_pkg::control_of(run_len_ff);
      push.grp_a.value          = pend_value_ff;
      push.grp_a.item_last      = !flush_b;
      push.grp_a.stream_end     = 1'b0;
      // group b: the entry after this byte, on a full run or end of stream
      push.en_b                 = accept && flush_b;
      push.grp_b.control        = rlbe_pkg::control_of(new_run);
      push.grp_b.value          = req_chan.data_byte;
      push.grp_b.item_last      = 1'b1;
      push.grp_b.stream_end     = req_chan.stream_last;

      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      run_len_in    = run_len_ff;
      if (accept) begin
         if (flush_b) begin
            pend_valid_in = 1'b0;
            pend_value_in = '0;
            run_len_in    = '0;
         end else begin
            pend_valid_in = 1'b1;
            pend_value_in = req_chan.data_byte;
            run_len_in    = new_run;
         end
      end

      max_run_in = csr_wr_en ? csr_wr_data : max_run_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_value_ff <= '0;
         run_len_ff    <= '0;
         max_run_ff    <= rlbe_pkg::MAX_RUN_RESET;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_value_ff <= pend_value_in;
         run_len_ff    <= run_len_in;
         max_run_ff    <= max_run_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.stream_last |=> !pend_valid_ff)
      else $error("pending entry survived end of stream");

   // a lowered max_run may leave a longer run pending, so only zero is illegal
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (run_len_ff != 7'd0))
      else $error("pending run length out of range");

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (push.en_a || push.en_b) |-> accept)
      else $error("group pushed without a transfer");

endmodule
`default_nettype wire

### src/rlbe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbe_queue
// Short group queue between front and back end: takes up to two groups a
// cycle, hands out one at a time from its head.
// ----------------------------------------------------------------------------
module rlbe_queue #(
   parameter int Depth = rlbe_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rlbe_pkg::push_type   push,
   output logic                      space_ok,
   output logic                      not_empty,
   output rlbe_pkg::group_type       head,
   input  wire logic                 pop
);

   localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   rlbe_pkg::group_type mem_ff [Depth];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff,  count_in;
   logic [CW-1:0]       push_n;
   rlbe_pkg::group_type first;

   always_comb begin
      push_n    = CW'(push.en_a) + CW'(push.en_b);
      first     = push.en_a ? push.grp_a : push.grp_b;
      space_ok  = count_ff <= CW'(Depth - 2);
      not_empty = count_ff != '0;
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff + PW'(push_n);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + push_n - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         mem_ff[wr_ptr_ff] <= first;
      end
      if (push.en_a && push.en_b) begin
         mem_ff[wr_ptr_ff + PW'(1)] <= push.grp_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(Depth))
      else $error("group queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty group queue");

   a_room_for_push: assert property (@(posedge clock) disable iff (reset)
      (push_n != '0) |-> space_ok)
      else $error("push without room for two groups");

endmodule
`default_nettype wire

### src/rlbe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlbe_back
// Serializes each queued group into a control byte and a data byte through
// a registered output stage.
// ----------------------------------------------------------------------------
module rlbe_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 not_empty,
   input  wire rlbe_pkg::group_type  head,
   output logic                      pop,
   rlbe_rsp_if.source                rsp_chan
);

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rlbe_pkg::DATA_W-1:0] code_ff,      code_in;
   logic                        item_last_ff, item_last_in;
   logic                        stream_end_ff, stream_end_in;
   logic                        phase_ff,     phase_in;
   logic                        free;
   logic                        load;

   always_comb begin
      free          = !rsp_valid_ff || rsp_chan.ready;
      load          = free && not_empty;
      pop           = load && phase_ff;
      rsp_valid_in  = free ? not_empty : rsp_valid_ff;
      code_in       = code_ff;
      item_last_in  = item_last_ff;
      stream_end_in = stream_end_ff;
      phase_in      = phase_ff;
      if (load) begin
         // first byte of a group is the control byte, second the data byte
         code_in       = phase_ff ? head.value : head.control;
         item_last_in  = phase_ff && head.item_last;
         stream_end_in = phase_ff && head.stream_end;
         phase_in      = !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      item_last_ff  <= item_last_in;
      stream_end_ff <= stream_end_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.code_byte  = code_ff;
   assign rsp_chan.item_last  = item_last_ff;
   assign rsp_chan.stream_end = stream_end_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && stream_end_ff |-> item_last_ff)
      else $error("stream end without item last");

   a_last_on_data_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && item_last_ff |-> !phase_ff)
      else $error("item last on a control byte");

   a_pop_after_data: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff && !phase_ff)
      else $error("group popped before its data byte");

endmodule
`default_nettype wire

### src/run_length_byte_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// run_length_byte_encoder
// Run-length encoder for a byte stream with an end-of-stream marker.
// ----------------------------------------------------------------------------
// Each input byte either extends the pending run or flushes groups of two
// output bytes: (0x80 | count, byte) for a run of two or more, (0x01, byte)
// for a single byte. A run reaching csr max_run (values below 2 act as 2) or
// an input marked stream_last flushes at once. Bytes that only extend a run
// are taken every cycle while the queue has room for two groups; each flushed
// group goes out of the one-byte output port as two bytes, so on data that
// flushes on every byte the sustained rate is set by the output serializer.
// A transfer in passes through a queue entry and the registered output stage
// to its first byte out. A four-entry group queue between the front end and
// the serializer absorbs output stalls; the front end takes a byte only while
// the queue has room for two groups.
// ----------------------------------------------------------------------------
module run_length_byte_encoder #(
   parameter int QueueDepth = rlbe_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   rlbe_req_if.sink                         req_chan,
   rlbe_rsp_if.source                       rsp_chan,
   input  wire logic                        csr_wr_en,
   input  wire logic [rlbe_pkg::RUN_W-1:0]  csr_wr_data
);

   rlbe_pkg::push_type  push;
   rlbe_pkg::group_type head;
   logic                space_ok;
   logic                not_empty;
   logic                pop;

   rlbe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .space_ok    (space_ok),
      .push        (push)
   );

   rlbe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop)
   );

   rlbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

### dv/rlbe_code_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbe_code_checker
// Watches both byte channels of the run-length encoder, rebuilds the code
// stream that each accepted input byte must produce, and compares every
// output transfer with the oldest code byte still owed.
// ----------------------------------------------------------------------------
module rlbe_code_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   rlbe_req_if                             req_mon,
   rlbe_rsp_if                             rsp_mon,
   input  wire logic                       csr_wr_en,
   input  wire logic [rlbe_pkg::RUN_W-1:0] csr_wr_data,
   output int                              fail_count,
   output int                              codes_owed,
   output int                              bytes_in,
   output int                              codes_out,
   output int                              cap_flushes,
   output int                              streams_closed
);

   localparam logic [rlbe_pkg::DATA_W-1:0] RUN_FLAG    = 8'h80;
   localparam int                          PRINT_LIMIT = 40;

   typedef struct packed {
      logic [rlbe_pkg::DATA_W-1:0] code;
      logic                        item_last;
      logic                        stream_end;
   } code_rec_type;

   code_rec_type owed_q[$];
   code_rec_type step_codes[4];
   int           step_n;

   logic                        held_valid;
   logic [rlbe_pkg::DATA_W-1:0] held_byte;
   logic [rlbe_pkg::RUN_W-1:0]  held_count;
   logic [rlbe_pkg::RUN_W-1:0]  run_cap;

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // emit the held entry as a two-byte group and forget it
   task automatic flush_held();
      logic [rlbe_pkg::DATA_W-1:0] ctrl;
      if (held_valid) begin
         ctrl = (held_count >= rlbe_pkg::MIN_RUN) ? (RUN_FLAG | {1'b0, held_count})
                                                  : rlbe_pkg::LITERAL_ONE;
         step_codes[step_n] = '{code: ctrl, item_last: 1'b0, stream_end: 1'b0};
         step_n++;
         step_codes[step_n] = '{code: held_byte, item_last: 1'b0, stream_end: 1'b0};
         step_n++;
         held_valid = 1'b0;
         held_byte  = '0;
         held_count = '0;
      end
   endtask

   task automatic encode_byte(input logic [rlbe_pkg::DATA_W-1:0] b, input logic last);
      logic [rlbe_pkg::RUN_W-1:0] cap;
      cap = (run_cap < rlbe_pkg::MIN_RUN) ? rlbe_pkg::MIN_RUN : run_cap;
      step_n = 0;
      if (held_valid && b == held_byte && held_count < cap) begin
         held_count = held_count + 1'b1;
      end else begin
         flush_held();
         held_valid = 1'b1;
         held_byte  = b;
         held_count = 7'd1;
      end
      if (held_count >= cap || last) begin
         if (held_count >= cap) begin
            cap_flushes++;
         end
         flush_held();
      end
      if (step_n > 0) begin
         step_codes[step_n-1].item_last  = 1'b1;
         step_codes[step_n-1].stream_end = last;
      end
      if (last) begin
         streams_closed++;
      end
      for (int i = 0; i < step_n; i++) begin
         owed_q.push_back(step_codes[i]);
      end
   endtask

   task automatic check_code(input code_rec_type got);
      code_rec_type want;
      codes_out++;
      if (owed_q.size() == 0) begin
         report_mismatch($sformatf("code byte %02h arrived with nothing owed", got.code));
      end else begin
         want = owed_q.pop_front();
         if (got.code != want.code) begin
            report_mismatch($sformatf("code_byte expected %02h got %02h",
                                      want.code, got.code));
         end
         if (got.item_last != want.item_last) begin
            report_mismatch($sformatf("item_last expected %0b got %0b on code %02h",
                                      want.item_last, got.item_last, want.code));
         end
         if (got.stream_end != want.stream_end) begin
            report_mismatch($sformatf("stream_end expected %0b got %0b on code %02h",
                                      want.stream_end, got.stream_end, want.code));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_valid = 1'b0;
         held_byte  = '0;
         held_count = '0;
         run_cap    = rlbe_pkg::MAX_RUN_RESET;
         owed_q.delete();
      end else begin
         if (csr_wr_en) begin
            run_cap = csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            bytes_in++;
            encode_byte(req_mon.data_byte, req_mon.stream_last);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_code('{code: rsp_mon.code_byte, item_last: rsp_mon.item_last,
                         stream_end: rsp_mon.stream_end});
         end
      end
      codes_owed <= owed_q.size();
   end

endmodule

### dv/run_length_byte_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_byte_encoder_tb
// Drives byte streams into the run-length encoder under random stalls on both
// channels and several max_run settings; a checker beside the block predicts
// and compares the code stream, and this module gives the verdict.
// ----------------------------------------------------------------------------
module run_length_byte_encoder_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int STALL_PCT      = 20;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [rlbe_pkg::RUN_W-1:0] csr_wr_data;
   logic                       stall_en;

   int fail_count;
   int codes_owed;
   int bytes_in;
   int codes_out;
   int cap_flushes;
   int streams_closed;
   int quiet_cycles;

   rlbe_req_if req_bus ();
   rlbe_rsp_if rsp_bus ();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   run_length_byte_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rlbe_code_checker code_chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .codes_owed     (codes_owed),
      .bytes_in       (bytes_in),
      .codes_out      (codes_out),
      .cap_flushes    (cap_flushes),
      .streams_closed (streams_closed)
   );

   // output side back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= !stall_en || ($urandom_range(0, 99) >= STALL_PCT);
   end

   // no transfer on either channel for too long means the block is stuck
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic push_byte(input logic [rlbe_pkg::DATA_W-1:0] b, input logic last);
      while (stall_en && $urandom_range(0, 99) < STALL_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.stream_last <= last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (codes_owed != 0);
      // a byte that only extends a run leaves nothing owed but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_max_run(input logic [rlbe_pkg::RUN_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_run(input logic [rlbe_pkg::DATA_W-1:0] b, input int len,
                           input logic close);
      logic last;
      for (int i = 0; i < len; i++) begin
         last = (close && i == len - 1) || ($urandom_range(0, 99) < 2);
         push_byte(b, last);
      end
   endtask

   task automatic run_phase(input logic [rlbe_pkg::RUN_W-1:0] cap, input int budget,
                            input logic calm);
      int                          sent;
      int                          len;
      int                          eff;
      logic [rlbe_pkg::DATA_W-1:0] b;
      logic [rlbe_pkg::DATA_W-1:0] prev;
      sent = 0;
      eff  = (cap < rlbe_pkg::MIN_RUN) ? int'(rlbe_pkg::MIN_RUN) : int'(cap);
      prev = 8'($urandom_range(0, 255));
      write_max_run(cap);
      stall_en <= !calm;
      while (sent < budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = 1;
            5, 6, 7:       len = $urandom_range(2, 4);
            8:             len = $urandom_range(eff - 1, eff + 1);
            default:       len = $urandom_range(1, 2 * eff);
         endcase
         // keep the phase close to its byte budget
         if (len > budget - sent) begin
            len = budget - sent;
         end
         case ($urandom_range(0, 9))
            6:       b = prev;
            7:       b = 8'h00;
            8:       b = 8'hFF;
            9:       b = 8'($urandom_range(0, 3));
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_run(b, len, $urandom_range(0, 9) == 0);
         prev = b;
         sent += len;
      end
   endtask

   initial begin
      reset               = 1'b1;
      stall_en            = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.stream_last = 1'b0;
      rsp_bus.ready       = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset max_run: short runs, literals, stream ends on runs and singles
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'h5A, 1'b1);
      // shortest cap: full runs go out at once, an equal byte starts over
      write_max_run(7'd2);
      push_byte(8'h33, 1'b0);
      push_byte(8'h33, 1'b0);
      push_byte(8'h33, 1'b0);
      push_byte(8'h33, 1'b0);
      push_byte(8'h80, 1'b1);
      // caps below two behave as two
      write_max_run(7'd0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h7F, 1'b1);
      write_max_run(7'd1);
      push_byte(8'h01, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'hFE, 1'b1);
      write_max_run(7'd3);
      push_byte(8'hC3, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'h3C, 1'b1);

      run_phase(7'd127, 140, 1'b0);
      run_phase(7'd2, 45, 1'b0);
      run_phase(7'd0, 45, 1'b0);
      run_phase(7'($urandom_range(3, 20)), 45, 1'b1);
      run_phase(7'd1, 45, 1'b0);
      run_phase(7'($urandom_range(21, 126)), 45, 1'b0);
      run_phase(7'd126, 45, 1'b0);
      run_phase(7'($urandom_range(2, 8)), 40, 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b1);

      wait_drained();
      $display("covered %0d byte transfers in and %0d code bytes out over %0d streams",
               bytes_in, codes_out, streams_closed);
      $display("%0d runs forced out at the cap; max_run taken through 0, 1, 2, 126, 127",
               cap_flushes);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
